### sv/oaid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaid_pkg: shared types and codes for the ordered array insert/delete unit
// Operation codes, the word type and the control bundle broadcast to cells.
// ----------------------------------------------------------------------------
package oaid_pkg;

  localparam logic [2:0] MODE_CLEAR     = 3'd0;
  localparam logic [2:0] MODE_INSERT    = 3'd1;
  localparam logic [2:0] MODE_OVERWRITE = 3'd2;
  localparam logic [2:0] MODE_DELETE    = 3'd3;
  localparam logic [2:0] MODE_READ      = 3'd4;

  typedef logic signed [31:0] word_t;

  // Broadcast to every cell of the chain for one accepted item
  typedef struct packed {
    logic       ins;   // accepted insert that is valid
    logic       del;   // accepted delete that is valid
    logic       wr;    // accepted overwrite that is valid
    logic       rd;    // accepted read that is valid
    logic [7:0] pos;   // target index
    word_t      data;  // word to store
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/ordered_array_insert_delete_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_unit: ordered list with insert/delete by shift
// A row of CAPACITY cells, each holding one signed word, plus a fill count.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one item carries a mode, a position
//   and a data word. Clear empties the list; insert moves the entries from the
//   position upward one place and stores the word; overwrite replaces one
//   entry; delete closes the gap; read returns an entry. A bad position, a
//   full list on insert or an unknown mode gives status 1 and changes nothing.
//   Result channel (out_valid / out_stall): one item per input item, in order,
//   with status, the read word (zero unless a successful read) and the fill
//   count after the operation.
//   An item passes the middle stage, then the output stage, to out_valid;
//   one item is taken every cycle while in_stall is low. Every cell shifts
//   at once on the accepting edge; the read word passes a two-level select
//   tree (groups of sixteen cells, then across groups), one level per stage.
//   Reset clears the fill count and both pipeline valids; entry contents are
//   not cleared and only entries below the count are ever visible.
//   When the receiver stalls, the output register holds; the middle stage
//   fills behind it and then in_stall rises until the output moves.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_mode,
  input  wire logic [7:0]      in_position,
  input  wire oaid_pkg::word_t in_data_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_status,
  output oaid_pkg::word_t      out_read_word,
  output logic [7:0]           out_fill_count
);
  import oaid_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CNT_W > 8) ? CNT_W : 8;
  localparam int unsigned GROUP = 16;
  localparam int unsigned N_GRP = (CAPACITY + GROUP - 1) / GROUP;
  localparam int unsigned N_PAD = N_GRP * GROUP;

  // Fill count
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W+7:0] cnt_ext;

  // Handshake and pipeline enables
  logic accept;
  logic en_out;
  logic en1;

  // Operation decode
  logic [CW-1:0] pos_x;
  logic [CW-1:0] cnt_x;
  logic          is_clear;
  logic          ins_ok;
  logic          wr_ok;
  logic          del_ok;
  logic          rd_ok;
  logic          status;
  cell_ctrl_t    ctrl;

  // Cell chain and read tree
  word_t entry_w [CAPACITY];
  word_t sel_w   [N_PAD];
  word_t grp_nxt [N_GRP];
  word_t grp_r   [N_GRP];
  word_t rd_nxt;

  // Middle stage
  logic       v1_r;
  logic       st1_r;
  logic [7:0] fill1_r;

  // Output stage
  logic       out_valid_r;
  logic       out_status_r;
  word_t      out_read_word_r;
  logic [7:0] out_fill_r;

  // Advance a stage when it is empty or the one after it advances
  assign en_out   = !out_valid_r || !out_stall;
  assign en1      = !v1_r || en_out;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  assign pos_x = CW'(in_position);
  assign cnt_x = CW'(cnt_r);

  assign is_clear = (in_mode == MODE_CLEAR);
  assign ins_ok   = (in_mode == MODE_INSERT) && (pos_x <= cnt_x)
                    && (cnt_r < CNT_W'(CAPACITY));
  assign wr_ok    = (in_mode == MODE_OVERWRITE) && (pos_x < cnt_x);
  assign del_ok   = (in_mode == MODE_DELETE) && (pos_x < cnt_x);
  assign rd_ok    = (in_mode == MODE_READ) && (pos_x < cnt_x);
  assign status   = !(is_clear || ins_ok || wr_ok || del_ok || rd_ok);

  assign ctrl.ins  = accept && ins_ok;
  assign ctrl.del  = accept && del_ok;
  assign ctrl.wr   = accept && wr_ok;
  assign ctrl.rd   = accept && rd_ok;
  assign ctrl.pos  = in_position;
  assign ctrl.data = in_data_word;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (is_clear) begin
        cnt_nxt = '0;
      end else if (ins_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (del_ok) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  // Report the count modulo 256
  assign cnt_ext = {8'd0, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Row of cells; each neighbour hands its word across on a shift
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    oaid_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .entry_word (entry_w[i]),
      .sel_word   (sel_w[i])
    );
  end

  // Pad the last group with zeros
  for (genvar i = CAPACITY; i < N_PAD; i++) begin : g_pad
    assign sel_w[i] = '0;
  end

  // First level of the read tree: merge each group of cells
  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        grp_nxt[g] = grp_nxt[g] | sel_w[g*GROUP + k];
      end
    end
  end

  // Second level: merge the groups
  always_comb begin
    rd_nxt = '0;
    for (int g = 0; g < N_GRP; g++) begin
      rd_nxt = rd_nxt | grp_r[g];
    end
  end

  // Middle stage: hold while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      st1_r   <= status;
      fill1_r <= cnt_ext[7:0];
      grp_r   <= grp_nxt;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_status_r    <= st1_r;
      out_read_word_r <= rd_nxt;
      out_fill_r      <= fill1_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_word  = out_read_word_r;
  assign out_fill_count = out_fill_r;

  // The count never goes past the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // A rejected item never carries a read word
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_read_word_r == '0)
    else $error("rejected item with non-zero read word");

  // An accepted clear empties the list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_clear |=> cnt_r == '0)
    else $error("clear did not empty the list");

  // A valid insert grows the list by one
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ins_ok |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  // A valid delete shrinks the list by one
  a_delete: assert property (@(posedge clk) disable iff (!rst_n)
    accept && del_ok |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("delete did not shrink the list");

endmodule
`default_nettype wire

### sv/oaid_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaid_cell: one entry of the list
// Holds one word; takes new data, left word on insert, right word on delete.
// ----------------------------------------------------------------------------
module oaid_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic               clk,
  input  wire oaid_pkg::cell_ctrl_t ctrl,
  input  wire oaid_pkg::word_t    left_word,
  input  wire oaid_pkg::word_t    right_word,
  output oaid_pkg::word_t         entry_word,
  output oaid_pkg::word_t         sel_word
);
  import oaid_pkg::*;

  word_t entry_r;
  word_t entry_nxt;
  logic  hit;
  logic  pos_below;

  assign hit       = ({24'd0, ctrl.pos} == 32'(IDX));
  assign pos_below = ({24'd0, ctrl.pos} <  32'(IDX));

  always_comb begin
    entry_nxt = entry_r;
    if ((ctrl.ins || ctrl.wr) && hit) begin
      entry_nxt = ctrl.data;
    end else if (ctrl.ins && pos_below) begin
      entry_nxt = left_word;
    end else if (ctrl.del && (hit || pos_below)) begin
      entry_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_word = entry_r;
  // Drive the word onto the read tree only when this cell is addressed
  assign sel_word   = (ctrl.rd && hit) ? entry_r : '0;

endmodule
`default_nettype wire
